// ===== rtl/vlbuf_pkg.sv =====
`default_nettype none

package vlbuf_pkg;

  // Request kinds.
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_BOND  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Field widths.
  localparam int SITE_W   = 12;
  localparam int CAP_W    = 3;
  localparam int BOND_W   = 14;
  localparam int COUNT_W  = 13;
  localparam int MOMENT_W = 25;

  // A link entry holds a root flag above a 16-bit size or parent field.
  localparam int SIZE_W = 16;
  localparam int LINK_W = SIZE_W + 1;
  localparam int VC_W   = 2 * CAP_W;

  localparam logic [SIZE_W-1:0]  SIZE_MAX = 16'hFFFF;
  localparam logic [COUNT_W-1:0] BIG_MAX  = 13'h1FFF;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LOAD,
    OP_CLEAR,
    OP_RD_VA,
    OP_RD_VB,
    OP_BUMP_A,
    OP_BUMP_B,
    OP_WALK_A,
    OP_WALK_B,
    OP_SIZE_A,
    OP_SIZE_B,
    OP_MUL,
    OP_MERGE1,
    OP_MERGE2,
    OP_REPORT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       sites_ok;
    logic       bond_ok;
    logic       walk_done;
    logic       same_root;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/valence_limited_bond_union_find_unit.sv =====
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    kind, site_a, site_b, capacity
// out_      output     out_valid / out_ready  accepted, merged, bonds_taken, sites_touched,
//                                             largest_cluster, size_moment
//
// One request is in flight at a time. A load, clear, unused kind or bond on bad sites goes
// from decode to the report, a bond failing the capacity check from the check. An adsorbed
// bond bumps both valences, walks each site to its root with path depth plus one link reads
// (at most SITES) and merges the clusters if the roots differ; the single read port of the
// link memory sets one walk step per cycle. Reset sets only the run counters (counts to
// zero, size moment to SITES); site stores hold nothing until each site is loaded. A finished
// result waits until the output register is free; the next request is taken once it is there.
`default_nettype none

module valence_limited_bond_union_find_unit #(
  parameter int SITES = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_kind,
  input  wire logic [vlbuf_pkg::SITE_W-1:0]      in_site_a,
  input  wire logic [vlbuf_pkg::SITE_W-1:0]      in_site_b,
  input  wire logic [vlbuf_pkg::CAP_W-1:0]       in_capacity,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_accepted,
  output logic                                   out_merged,
  output logic      [vlbuf_pkg::BOND_W-1:0]      out_bonds_taken,
  output logic      [vlbuf_pkg::COUNT_W-1:0]     out_sites_touched,
  output logic      [vlbuf_pkg::COUNT_W-1:0]     out_largest_cluster,
  output logic      [vlbuf_pkg::MOMENT_W-1:0]    out_size_moment
);

  vlbuf_pkg::dp_cmd_t    cmd;
  vlbuf_pkg::dp_status_t status;

  vlbuf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  vlbuf_dp #(.SITES(SITES)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_kind             (in_kind),
    .in_site_a           (in_site_a),
    .in_site_b           (in_site_b),
    .in_capacity         (in_capacity),
    .out_accepted        (out_accepted),
    .out_merged          (out_merged),
    .out_bonds_taken     (out_bonds_taken),
    .out_sites_touched   (out_sites_touched),
    .out_largest_cluster (out_largest_cluster),
    .out_size_moment     (out_size_moment)
  );

endmodule

`default_nettype wire

// ===== rtl/vlbuf_ram.sv =====
`default_nettype none

module vlbuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/vlbuf_ctrl.sv =====
`default_nettype none

module vlbuf_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output vlbuf_pkg::dp_cmd_t         cmd,
  input  wire vlbuf_pkg::dp_status_t status
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_VB,
    S_CHECK,
    S_BUMP_B,
    S_WALK_A,
    S_ISSUE_B,
    S_WALK_B,
    S_SIZE_A,
    S_SIZE_B,
    S_MUL,
    S_MERGE1,
    S_MERGE2,
    S_REPORT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = vlbuf_pkg::OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = vlbuf_pkg::OP_CAPTURE;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_REPORT;
        case (status.kind)
          vlbuf_pkg::KIND_LOAD:  cmd.op = vlbuf_pkg::OP_LOAD;
          vlbuf_pkg::KIND_CLEAR: cmd.op = vlbuf_pkg::OP_CLEAR;
          vlbuf_pkg::KIND_BOND: begin
            if (status.sites_ok) begin
              cmd.op    = vlbuf_pkg::OP_RD_VA;
              state_nxt = S_RD_VB;
            end
          end
          default: cmd.op = vlbuf_pkg::OP_NONE;
        endcase
      end
      S_RD_VB: begin
        cmd.op    = vlbuf_pkg::OP_RD_VB;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (status.bond_ok) begin
          cmd.op    = vlbuf_pkg::OP_BUMP_A;
          state_nxt = S_BUMP_B;
        end else begin
          state_nxt = S_REPORT;
        end
      end
      S_BUMP_B: begin
        cmd.op    = vlbuf_pkg::OP_BUMP_B;
        state_nxt = S_WALK_A;
      end
      S_WALK_A: begin
        cmd.op = vlbuf_pkg::OP_WALK_A;
        if (status.walk_done) begin
          state_nxt = S_ISSUE_B;
        end
      end
      S_ISSUE_B: begin
        state_nxt = S_WALK_B;
      end
      S_WALK_B: begin
        cmd.op = vlbuf_pkg::OP_WALK_B;
        if (status.walk_done) begin
          state_nxt = S_SIZE_A;
        end
      end
      S_SIZE_A: begin
        cmd.op    = vlbuf_pkg::OP_SIZE_A;
        state_nxt = status.same_root ? S_REPORT : S_SIZE_B;
      end
      S_SIZE_B: begin
        cmd.op    = vlbuf_pkg::OP_SIZE_B;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op    = vlbuf_pkg::OP_MUL;
        state_nxt = S_MERGE1;
      end
      S_MERGE1: begin
        cmd.op    = vlbuf_pkg::OP_MERGE1;
        state_nxt = S_MERGE2;
      end
      S_MERGE2: begin
        cmd.op    = vlbuf_pkg::OP_MERGE2;
        state_nxt = S_REPORT;
      end
      S_REPORT: begin
        // The result waits here until the output register is free.
        if (out_free) begin
          cmd.op        = vlbuf_pkg::OP_REPORT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another was in flight");

  a_report_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REPORT) && out_free |=> out_valid_r && (state_r == S_IDLE))
    else $error("finished result did not reach the output register");

  a_walk_bounded_by_check: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BUMP_B) |-> $past(status.bond_ok))
    else $error("valences bumped without a passing capacity check");

endmodule

`default_nettype wire

// ===== rtl/vlbuf_dp.sv =====
`default_nettype none

module vlbuf_dp #(
  parameter int SITES = 4096
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire vlbuf_pkg::dp_cmd_t                 cmd,
  output vlbuf_pkg::dp_status_t                   status,
  input  wire logic [1:0]                         in_kind,
  input  wire logic [vlbuf_pkg::SITE_W-1:0]       in_site_a,
  input  wire logic [vlbuf_pkg::SITE_W-1:0]       in_site_b,
  input  wire logic [vlbuf_pkg::CAP_W-1:0]        in_capacity,
  output logic                                    out_accepted,
  output logic                                    out_merged,
  output logic      [vlbuf_pkg::BOND_W-1:0]       out_bonds_taken,
  output logic      [vlbuf_pkg::COUNT_W-1:0]      out_sites_touched,
  output logic      [vlbuf_pkg::COUNT_W-1:0]      out_largest_cluster,
  output logic      [vlbuf_pkg::MOMENT_W-1:0]     out_size_moment
);

  localparam int AW     = $clog2(SITES);
  localparam int IDX_W  = vlbuf_pkg::SIZE_W + 1;
  localparam int SIZE_W = vlbuf_pkg::SIZE_W;
  localparam int LINK_W = vlbuf_pkg::LINK_W;
  localparam int VC_W   = vlbuf_pkg::VC_W;
  localparam int CAP_W  = vlbuf_pkg::CAP_W;

  function automatic logic [SIZE_W-1:0] size_of(input logic [LINK_W-1:0] lk);
    return lk[LINK_W-1] ? lk[SIZE_W-1:0] : '0;
  endfunction

  // Captured request.
  logic [1:0]                    kind_r, kind_nxt;
  logic [vlbuf_pkg::SITE_W-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [CAP_W-1:0]              cap_r, cap_nxt;

  // Bond work registers.
  logic [VC_W-1:0]   vca_r, vca_nxt, vcb_r, vcb_nxt;
  logic [AW-1:0]     cur_r, cur_nxt, steps_r, steps_nxt;
  logic [AW-1:0]     ra_r, ra_nxt, rb_r, rb_nxt;
  logic [SIZE_W-1:0] sa_r, sa_nxt, sb_r, sb_nxt;
  logic [31:0]       prod_r, prod_nxt;
  logic              acc_r, acc_nxt, mrg_r, mrg_nxt;

  // Run counters.
  logic [vlbuf_pkg::BOND_W-1:0]   bond_r, bond_nxt;
  logic [vlbuf_pkg::COUNT_W-1:0]  site_r, site_nxt, big_r, big_nxt;
  logic [vlbuf_pkg::MOMENT_W-1:0] mom_r, mom_nxt;

  // Memories.
  logic              vc_we, link_we;
  logic [AW-1:0]     vc_waddr, vc_raddr, link_waddr, link_raddr;
  logic [VC_W-1:0]   vc_wdata, vc_rdata;
  logic [LINK_W-1:0] link_wdata, link_rdata;

  // Decoded values.
  logic [IDX_W-1:0]  a_ext, b_ext, p_ext;
  logic              a_ok, b_ok;
  logic [AW-1:0]     addr_a, addr_b, next_site, walk_res, keep, drop;
  logic              walk_stop, walk_limit, walk_op;
  logic [IDX_W-1:0]  total;
  logic [SIZE_W-1:0] total_sat;
  logic [CAP_W-1:0]  va, ca, vb, cb;

  assign a_ext  = {{(IDX_W-vlbuf_pkg::SITE_W){1'b0}}, a_r};
  assign b_ext  = {{(IDX_W-vlbuf_pkg::SITE_W){1'b0}}, b_r};
  assign a_ok   = a_ext < IDX_W'(SITES);
  assign b_ok   = b_ext < IDX_W'(SITES);
  assign addr_a = a_ext[AW-1:0];
  assign addr_b = b_ext[AW-1:0];

  assign va = vca_r[CAP_W-1:0];
  assign ca = vca_r[VC_W-1:CAP_W];
  assign vb = vc_rdata[CAP_W-1:0];
  assign cb = vc_rdata[VC_W-1:CAP_W];

  // One link read per cycle of a walk: the next address comes straight from the read data.
  assign p_ext      = {1'b0, link_rdata[SIZE_W-1:0]};
  assign next_site  = p_ext[AW-1:0];
  assign walk_stop  = link_rdata[LINK_W-1] || (p_ext >= IDX_W'(SITES));
  assign walk_limit = (steps_r == AW'(SITES - 1));
  assign walk_res   = walk_stop ? cur_r : next_site;
  assign walk_op    = (cmd.op == vlbuf_pkg::OP_WALK_A) || (cmd.op == vlbuf_pkg::OP_WALK_B);

  // Ties keep the first root.
  assign keep      = (sa_r < sb_r) ? rb_r : ra_r;
  assign drop      = (sa_r < sb_r) ? ra_r : rb_r;
  assign total     = {1'b0, sa_r} + {1'b0, sb_r};
  assign total_sat = total[IDX_W-1] ? vlbuf_pkg::SIZE_MAX : total[SIZE_W-1:0];

  assign status.kind      = kind_r;
  assign status.sites_ok  = a_ok && b_ok && (a_r != b_r);
  assign status.bond_ok   = (va < ca) && (vb < cb);
  assign status.walk_done = walk_stop || walk_limit;
  assign status.same_root = (ra_r == rb_r);

  always_comb begin
    vc_we      = 1'b0;
    vc_waddr   = addr_a;
    vc_wdata   = {cap_r, {CAP_W{1'b0}}};
    vc_raddr   = (cmd.op == vlbuf_pkg::OP_RD_VB) ? addr_b : addr_a;
    link_we    = 1'b0;
    link_waddr = addr_a;
    link_wdata = {1'b1, SIZE_W'(1)};
    case (cmd.op)
      vlbuf_pkg::OP_SIZE_A: link_raddr = ra_r;
      vlbuf_pkg::OP_SIZE_B: link_raddr = rb_r;
      default:              link_raddr = (walk_op && !walk_stop) ? next_site : cur_r;
    endcase
    case (cmd.op)
      vlbuf_pkg::OP_LOAD: begin
        vc_we   = a_ok;
        link_we = a_ok;
      end
      vlbuf_pkg::OP_BUMP_A: begin
        vc_we    = 1'b1;
        vc_wdata = {ca, va + 1'b1};
      end
      vlbuf_pkg::OP_BUMP_B: begin
        vc_we    = 1'b1;
        vc_waddr = addr_b;
        vc_wdata = {vcb_r[VC_W-1:CAP_W], vcb_r[CAP_W-1:0] + 1'b1};
      end
      vlbuf_pkg::OP_MERGE1: begin
        link_we    = 1'b1;
        link_waddr = keep;
        link_wdata = {1'b1, total_sat};
      end
      vlbuf_pkg::OP_MERGE2: begin
        link_we    = 1'b1;
        link_waddr = drop;
        link_wdata = {1'b0, SIZE_W'(keep)};
      end
      default: link_we = 1'b0;
    endcase
  end

  always_comb begin
    kind_nxt  = kind_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    cap_nxt   = cap_r;
    vca_nxt   = vca_r;
    vcb_nxt   = vcb_r;
    cur_nxt   = cur_r;
    steps_nxt = steps_r;
    ra_nxt    = ra_r;
    rb_nxt    = rb_r;
    sa_nxt    = sa_r;
    sb_nxt    = sb_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    mrg_nxt   = mrg_r;
    bond_nxt  = bond_r;
    site_nxt  = site_r;
    big_nxt   = big_r;
    mom_nxt   = mom_r;
    case (cmd.op)
      vlbuf_pkg::OP_CAPTURE: begin
        kind_nxt = in_kind;
        a_nxt    = in_site_a;
        b_nxt    = in_site_b;
        cap_nxt  = in_capacity;
        acc_nxt  = 1'b0;
        mrg_nxt  = 1'b0;
      end
      vlbuf_pkg::OP_CLEAR: begin
        bond_nxt = '0;
        site_nxt = '0;
        big_nxt  = '0;
        mom_nxt  = vlbuf_pkg::MOMENT_W'(SITES);
      end
      vlbuf_pkg::OP_RD_VB: vca_nxt = vc_rdata;
      vlbuf_pkg::OP_BUMP_A: begin
        vcb_nxt   = vc_rdata;
        acc_nxt   = 1'b1;
        bond_nxt  = bond_r + 1'b1;
        site_nxt  = site_r + vlbuf_pkg::COUNT_W'(va == '0) + vlbuf_pkg::COUNT_W'(vb == '0);
        cur_nxt   = addr_a;
        steps_nxt = '0;
      end
      vlbuf_pkg::OP_WALK_A, vlbuf_pkg::OP_WALK_B: begin
        if (walk_stop || walk_limit) begin
          if (cmd.op == vlbuf_pkg::OP_WALK_A) begin
            ra_nxt    = walk_res;
            cur_nxt   = addr_b;
            steps_nxt = '0;
          end else begin
            rb_nxt = walk_res;
          end
        end else begin
          cur_nxt   = next_site;
          steps_nxt = steps_r + 1'b1;
        end
      end
      vlbuf_pkg::OP_SIZE_A: mrg_nxt = (ra_r != rb_r);
      vlbuf_pkg::OP_SIZE_B: sa_nxt = size_of(link_rdata);
      vlbuf_pkg::OP_MUL: begin
        sb_nxt   = size_of(link_rdata);
        prod_nxt = 32'(sa_r) * 32'(size_of(link_rdata));
      end
      vlbuf_pkg::OP_MERGE2: begin
        mom_nxt = mom_r + {prod_r[vlbuf_pkg::MOMENT_W-2:0], 1'b0};
        if (total_sat > SIZE_W'(big_r)) begin
          big_nxt = (total_sat > SIZE_W'(vlbuf_pkg::BIG_MAX)) ?
                    vlbuf_pkg::BIG_MAX : total_sat[vlbuf_pkg::COUNT_W-1:0];
        end
      end
      default: kind_nxt = kind_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bond_r <= '0;
      site_r <= '0;
      big_r  <= '0;
      mom_r  <= vlbuf_pkg::MOMENT_W'(SITES);
    end else begin
      bond_r <= bond_nxt;
      site_r <= site_nxt;
      big_r  <= big_nxt;
      mom_r  <= mom_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    cap_r   <= cap_nxt;
    vca_r   <= vca_nxt;
    vcb_r   <= vcb_nxt;
    cur_r   <= cur_nxt;
    steps_r <= steps_nxt;
    ra_r    <= ra_nxt;
    rb_r    <= rb_nxt;
    sa_r    <= sa_nxt;
    sb_r    <= sb_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    mrg_r   <= mrg_nxt;
    if (cmd.op == vlbuf_pkg::OP_REPORT) begin
      out_accepted        <= acc_r;
      out_merged          <= mrg_r;
      out_bonds_taken     <= bond_r;
      out_sites_touched   <= site_r;
      out_largest_cluster <= big_r;
      out_size_moment     <= mom_r;
    end
  end

  vlbuf_ram #(.WIDTH(VC_W), .DEPTH(SITES)) u_vc_ram (
    .clk   (clk),
    .we    (vc_we),
    .waddr (vc_waddr),
    .wdata (vc_wdata),
    .raddr (vc_raddr),
    .rdata (vc_rdata)
  );

  vlbuf_ram #(.WIDTH(LINK_W), .DEPTH(SITES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  a_bond_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == vlbuf_pkg::OP_BUMP_A) |=> (bond_r == $past(bond_r) + 1'b1))
    else $error("bond counter did not advance on an adsorbed bond");

  a_merge_distinct_roots: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == vlbuf_pkg::OP_MERGE1) |-> (ra_r != rb_r) && mrg_r)
    else $error("merge started on a single root");

  a_moment_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !((cmd.op == vlbuf_pkg::OP_MERGE2) || (cmd.op == vlbuf_pkg::OP_CLEAR)) |=> $stable(mom_r))
    else $error("size moment changed outside a merge or clear");

endmodule

`default_nettype wire
